### rtl/core/nbp_pkg.sv
// Shared widths, register codes and storage types of the n-body pair block.
`default_nettype none
package nbp_pkg;
	localparam int MAX_BODIES = 64;
	localparam int AW         = $clog2(MAX_BODIES);
	localparam int CNT_W      = $clog2(MAX_BODIES + 1);
	localparam int IDX_W      = 6;

	localparam int POS_W  = 32;
	localparam int MASS_W = 32;
	localparam int GRAV_W = 32;
	localparam int SOFT_W = 40;
	localparam int ACC_W  = 48;
	localparam int DIF_W  = 33;
	localparam int MAG_W  = 32;
	localparam int R2_W   = 50;
	localparam int ROOT_W = 44;
	localparam int DEN_W  = 91;
	localparam int NUM_W  = 104;
	localparam int TERM_W = ACC_W + 1;
	localparam int MUL_W  = 64;
	localparam int MUL_H  = MUL_W / 2;
	localparam int PROD_W = 2 * MUL_W;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 40;
	localparam logic [CFG_IDX_W-1:0] CFG_GRAV = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SOFT = 2'd1;
	localparam logic [GRAV_W-1:0] GRAV_RST = 32'd16777216;
	localparam logic [SOFT_W-1:0] SOFT_RST = 40'd65536;

	localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
	localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
	localparam logic [ACC_W-1:0] MAG_CAP = {1'b1, {(ACC_W-1){1'b0}}};

	typedef struct packed {
		logic signed [POS_W-1:0] x;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] z;
		logic [MASS_W-1:0]       m;
	} body_t;

	typedef struct packed {
		logic signed [ACC_W-1:0] x;
		logic signed [ACC_W-1:0] y;
		logic signed [ACC_W-1:0] z;
	} acc_t;
endpackage
`default_nettype wire

### rtl/core/nbp_ifs.sv
// Input and output channel interfaces of the n-body pair block.
`default_nettype none
interface nbp_in_if;
	import nbp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [POS_W-1:0] pos_x;
	logic signed [POS_W-1:0] pos_y;
	logic signed [POS_W-1:0] pos_z;
	logic [MASS_W-1:0]       body_mass;
	logic                    last_body;
	modport source(output valid, pos_x, pos_y, pos_z, body_mass, last_body, input ready);
	modport sink(input valid, pos_x, pos_y, pos_z, body_mass, last_body, output ready);
endinterface

interface nbp_out_if;
	import nbp_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        body_index;
	logic signed [ACC_W-1:0] acc_x;
	logic signed [ACC_W-1:0] acc_y;
	logic signed [ACC_W-1:0] acc_z;
	logic                    overflowed;
	logic                    last_result;
	modport source(output valid, body_index, acc_x, acc_y, acc_z, overflowed, last_result,
		input ready);
	modport sink(input valid, body_index, acc_x, acc_y, acc_z, overflowed, last_result,
		output ready);
endinterface
`default_nettype wire

### rtl/core/nbp_ram.sv
// Generic simple dual-port RAM with registered read.
`default_nettype none
module nbp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

### rtl/core/nbp_mul.sv
// Sequential 64x64 multiplier built from four registered 32x32 partial products.
`default_nettype none
module nbp_mul (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nbp_pkg::MUL_W-1:0]  a,
	input  logic [nbp_pkg::MUL_W-1:0]  b,
	output logic                       done,
	output logic [nbp_pkg::PROD_W-1:0] prod
);
	import nbp_pkg::*;

	logic [MUL_W-1:0]  a_q, b_q;
	logic              busy_q;
	logic [1:0]        step_q;
	logic [MUL_H-1:0]  ah, bh;
	logic [MUL_W-1:0]  pp_s1;
	logic [1:0]        sh_s1;
	logic              vld_s1, last_s1, done_q;
	logic [PROD_W-1:0] prod_q, pp_ext;

	assign ah = step_q[0] ? a_q[MUL_W-1:MUL_H] : a_q[MUL_H-1:0];
	assign bh = step_q[1] ? b_q[MUL_W-1:MUL_H] : b_q[MUL_H-1:0];

	always_comb begin
		case (sh_s1)
			2'd0:    pp_ext = {{MUL_W{1'b0}}, pp_s1};
			2'd1:    pp_ext = {{MUL_H{1'b0}}, pp_s1, {MUL_H{1'b0}}};
			default: pp_ext = {pp_s1, {MUL_W{1'b0}}};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			step_q  <= '0;
			vld_s1  <= 1'b0;
			last_s1 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vld_s1  <= busy_q;
			last_s1 <= busy_q && (step_q == 2'd3);
			done_q  <= vld_s1 && last_s1;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + 2'd1;
				if (step_q == 2'd3) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q    <= a;
			b_q    <= b;
			prod_q <= '0;
		end else if (vld_s1) begin
			prod_q <= prod_q + pp_ext;
		end
		pp_s1 <= MUL_W'(ah) * MUL_W'(bh);
		sh_s1 <= 2'(step_q[0]) + 2'(step_q[1]);
	end

	assign done = done_q;
	assign prod = prod_q;
endmodule
`default_nettype wire

### rtl/core/nbp_sqrt.sv
// Digit-by-digit square root of r2 scaled by 2^32, one result bit per cycle.
`default_nettype none
module nbp_sqrt (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [nbp_pkg::R2_W-1:0]   r2,
	output logic                       done,
	output logic [nbp_pkg::ROOT_W-1:0] root
);
	import nbp_pkg::*;

	localparam int RAD_W = 2 * ROOT_W;
	localparam int REM_W = ROOT_W + 4;
	localparam int CW    = $clog2(ROOT_W + 1);

	logic [RAD_W-1:0]  rad_q;
	logic [REM_W-1:0]  rem_q, rem_sh, trial;
	logic [ROOT_W-1:0] root_q;
	logic [CW-1:0]     cnt_q;
	logic              done_q, ge;

	assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1 -: 2]};
	assign trial  = {2'b00, root_q, 2'b01};
	assign ge     = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(ROOT_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= RAD_W'({r2, 32'b0});
			rem_q  <= '0;
			root_q <= '0;
		end else if (cnt_q != '0) begin
			rad_q  <= {rad_q[RAD_W-3:0], 2'b00};
			rem_q  <= ge ? rem_sh - trial : rem_sh;
			root_q <= {root_q[ROOT_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;
endmodule
`default_nettype wire

### rtl/core/nbp_div.sv
// Restoring divider, one quotient bit per cycle.
`default_nettype none
module nbp_div (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [nbp_pkg::NUM_W-1:0] num,
	input  logic [nbp_pkg::DEN_W-1:0] den,
	output logic                      done,
	output logic [nbp_pkg::NUM_W-1:0] quot
);
	import nbp_pkg::*;

	localparam int CW = $clog2(NUM_W + 1);

	logic [NUM_W-1:0] num_q, q_q;
	logic [DEN_W-1:0] den_q;
	logic [DEN_W:0]   rem_q, rem_sh;
	logic [CW-1:0]    cnt_q;
	logic             done_q, ge;

	assign rem_sh = {rem_q[DEN_W-1:0], num_q[NUM_W-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (cnt_q == CW'(1));
			if (start) begin
				cnt_q <= CW'(NUM_W);
			end else if (cnt_q != '0) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
			q_q   <= '0;
		end else if (cnt_q != '0) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			rem_q <= ge ? rem_sh - {1'b0, den_q} : rem_sh;
			q_q   <= {q_q[NUM_W-2:0], ge};
		end
	end

	assign done = done_q;
	assign quot = q_q;
endmodule
`default_nettype wire

### rtl/core/nbody_pairwise_acceleration_top.sv
// Top level of the all-pairs softened gravity block.
// Use: stream bodies (position, mass) on in_ch, one transaction per body; the body
// with last_body set closes the frame. Up to MAX_BODIES bodies are stored in load
// order; later ones are dropped and the frame's results carry overflowed.
// After the closing body the block visits every pair i<j once, then sends one
// transaction per stored body on out_ch in load order, last_result on the final one.
// While loading, every body offered on in_ch is taken. Each pair runs the bit-serial
// divider six times (one quotient per axis and side) and the square root once; the
// shared 64x64 multiplier forms three squares, one denominator, and per quotient a
// G*m and a numerator product. Results are sent one at a time.
// in_ch.ready is high only while loading; nothing is accepted during compute or
// output. A stalled out_ch holds the result register and the block waits.
// Reset: registers return to G = 1.0, softening = 1.0; count, drop flag and the
// accumulator valid bits clear, so every accumulator reads as zero.
// cfg writes are taken at any edge with cfg_we; write only while idle.
`default_nettype none
module nbody_pairwise_acceleration_top (
	input  logic                           clk,
	input  logic                           arst_n,
	nbp_in_if.sink                         in_ch,
	nbp_out_if.source                      out_ch,
	input  logic                           cfg_we,
	input  logic [nbp_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [nbp_pkg::CFG_DATA_W-1:0] cfg_data
);
	import nbp_pkg::*;

	// sequencer codes
	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_P_RDI  = 5'd1;
	localparam logic [4:0] S_P_RDJ  = 5'd2;
	localparam logic [4:0] S_P_DIF  = 5'd3;
	localparam logic [4:0] S_SQ_GO  = 5'd4;
	localparam logic [4:0] S_SQ_W   = 5'd5;
	localparam logic [4:0] S_RT_GO  = 5'd6;
	localparam logic [4:0] S_RT_ST  = 5'd7;
	localparam logic [4:0] S_RT_W   = 5'd8;
	localparam logic [4:0] S_DN_GO  = 5'd9;
	localparam logic [4:0] S_DN_W   = 5'd10;
	localparam logic [4:0] S_GM_GO  = 5'd11;
	localparam logic [4:0] S_GM_W   = 5'd12;
	localparam logic [4:0] S_NM_GO  = 5'd13;
	localparam logic [4:0] S_NM_W   = 5'd14;
	localparam logic [4:0] S_DV_GO  = 5'd15;
	localparam logic [4:0] S_DV_W   = 5'd16;
	localparam logic [4:0] S_AI_RD  = 5'd17;
	localparam logic [4:0] S_AI_WR  = 5'd18;
	localparam logic [4:0] S_AJ_RD  = 5'd19;
	localparam logic [4:0] S_AJ_WR  = 5'd20;
	localparam logic [4:0] S_E_RD   = 5'd21;
	localparam logic [4:0] S_E_CAP  = 5'd22;
	localparam logic [4:0] S_E_WAIT = 5'd23;

	// Saturating accumulate of one pair term.
	function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
			input logic signed [TERM_W-1:0] t);
		logic signed [ACC_W+1:0] s;
		s = (ACC_W+2)'(a) + (ACC_W+2)'(t);
		if (s > (ACC_W+2)'(ACC_MAX)) begin
			return ACC_MAX;
		end else if (s < (ACC_W+2)'(ACC_MIN)) begin
			return ACC_MIN;
		end
		return s[ACC_W-1:0];
	endfunction

	// Clip the quotient to 2^47 and apply the sign.
	function automatic logic signed [TERM_W-1:0] make_term(input logic [NUM_W-1:0] q,
			input logic neg);
		logic [ACC_W-1:0] qm;
		qm = (q > NUM_W'(MAG_CAP)) ? MAG_CAP : q[ACC_W-1:0];
		return neg ? -$signed({1'b0, qm}) : $signed({1'b0, qm});
	endfunction

	logic [4:0]              state_q;
	logic [CNT_W-1:0]        cnt_q, n_q, n_next;
	logic                    drop_q;
	logic [GRAV_W-1:0]       grav_q;
	logic [SOFT_W-1:0]       soft_q;
	logic [AW-1:0]           i_q, j_q, k_q;
	body_t                   bi_q, bj_q, in_body, pos_rdata;
	logic signed [DIF_W-1:0] d_q [3];
	logic signed [DIF_W-1:0] d_sel, d_neg;
	logic [MAG_W-1:0]        mag_ax;
	logic [1:0]              ax_q;
	logic                    side_q;
	logic [R2_W-1:0]         r2_q;
	logic [ROOT_W-1:0]       s_q;
	logic [DEN_W-1:0]        den_q;
	logic [MUL_W-1:0]        gm_q;
	logic [NUM_W-1:0]        num_q;
	logic signed [TERM_W-1:0] term_q [2][3];
	logic [MAX_BODIES-1:0]   acc_vld_q;
	logic                    acc_vld_s1;
	logic                    in_acc, room;

	logic                    out_vld_q, out_last_q, out_ovf_q;
	logic [IDX_W-1:0]        out_idx_q;
	acc_t                    out_acc_q;

	logic                    pos_we;
	logic [AW-1:0]           pos_raddr;
	logic                    acc_we;
	logic [AW-1:0]           acc_raddr, acc_waddr;
	acc_t                    acc_rdata, acc_cur, acc_wdata;

	logic                    mul_start, mul_done;
	logic [MUL_W-1:0]        mul_a, mul_b;
	logic [PROD_W-1:0]       mul_prod;
	logic                    sq_start, sq_done;
	logic [ROOT_W-1:0]       sq_root;
	logic                    dv_start, dv_done;
	logic [NUM_W-1:0]        dv_quot;

	assign in_acc  = in_ch.valid && in_ch.ready;
	assign room    = cnt_q < CNT_W'(MAX_BODIES);
	assign n_next  = room ? cnt_q + CNT_W'(1) : cnt_q;
	assign in_body = '{x: in_ch.pos_x, y: in_ch.pos_y, z: in_ch.pos_z, m: in_ch.body_mass};

	// axis operand for squares and numerators
	assign d_sel  = (ax_q == 2'd0) ? d_q[0] : (ax_q == 2'd1) ? d_q[1] : d_q[2];
	assign d_neg  = -d_sel;
	assign mag_ax = d_sel[DIF_W-1] ? d_neg[MAG_W-1:0] : d_sel[MAG_W-1:0];

	// body store: write at load, read i then j per pair
	assign pos_we    = in_acc && room;
	assign pos_raddr = (state_q == S_P_RDI) ? i_q : j_q;

	nbp_ram #(.WIDTH($bits(body_t)), .DEPTH(MAX_BODIES)) u_pos_ram (
		.clk(clk), .we(pos_we), .waddr(cnt_q[AW-1:0]), .wdata(in_body),
		.raddr(pos_raddr), .rdata(pos_rdata)
	);

	// accumulator store: read-modify-write of i, then of j; k during output
	always_comb begin
		case (state_q)
			S_AI_RD: acc_raddr = i_q;
			S_AJ_RD: acc_raddr = j_q;
			default: acc_raddr = k_q;
		endcase
	end

	assign acc_we    = (state_q == S_AI_WR) || (state_q == S_AJ_WR);
	assign acc_waddr = (state_q == S_AI_WR) ? i_q : j_q;
	assign acc_cur   = acc_vld_s1 ? acc_rdata : '0;

	always_comb begin
		if (state_q == S_AI_WR) begin
			acc_wdata.x = sat_add(acc_cur.x, term_q[0][0]);
			acc_wdata.y = sat_add(acc_cur.y, term_q[0][1]);
			acc_wdata.z = sat_add(acc_cur.z, term_q[0][2]);
		end else begin
			acc_wdata.x = sat_add(acc_cur.x, term_q[1][0]);
			acc_wdata.y = sat_add(acc_cur.y, term_q[1][1]);
			acc_wdata.z = sat_add(acc_cur.z, term_q[1][2]);
		end
	end

	nbp_ram #(.WIDTH($bits(acc_t)), .DEPTH(MAX_BODIES)) u_acc_ram (
		.clk(clk), .we(acc_we), .waddr(acc_waddr), .wdata(acc_wdata),
		.raddr(acc_raddr), .rdata(acc_rdata)
	);

	// shared multiplier operand select
	always_comb begin
		mul_start = 1'b0;
		mul_a     = '0;
		mul_b     = '0;
		case (state_q)
			S_SQ_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_W'(mag_ax);
				mul_b     = MUL_W'(mag_ax);
			end
			S_DN_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_W'(r2_q);
				mul_b     = MUL_W'(s_q);
			end
			S_GM_GO: begin
				mul_start = 1'b1;
				mul_a     = MUL_W'(grav_q);
				mul_b     = MUL_W'(side_q ? bi_q.m : bj_q.m);
			end
			S_NM_GO: begin
				mul_start = 1'b1;
				mul_a     = gm_q;
				mul_b     = MUL_W'(mag_ax);
			end
			default: ;
		endcase
	end

	assign sq_start = (state_q == S_RT_ST);
	assign dv_start = (state_q == S_DV_GO);

	nbp_mul u_mul (
		.clk(clk), .arst_n(arst_n), .start(mul_start), .a(mul_a), .b(mul_b),
		.done(mul_done), .prod(mul_prod)
	);

	nbp_sqrt u_sqrt (
		.clk(clk), .arst_n(arst_n), .start(sq_start), .r2(r2_q),
		.done(sq_done), .root(sq_root)
	);

	nbp_div u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(num_q), .den(den_q),
		.done(dv_done), .quot(dv_quot)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= GRAV_RST;
			soft_q <= SOFT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_GRAV: grav_q <= cfg_data[GRAV_W-1:0];
				CFG_SOFT: soft_q <= cfg_data[SOFT_W-1:0];
				default:  ;
			endcase
		end
	end

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			cnt_q     <= '0;
			n_q       <= '0;
			drop_q    <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			k_q       <= '0;
			ax_q      <= '0;
			side_q    <= 1'b0;
			acc_vld_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (acc_we) begin
				acc_vld_q[acc_waddr] <= 1'b1;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cnt_q <= n_next;
						if (!room) begin
							drop_q <= 1'b1;
						end
						if (in_ch.last_body) begin
							n_q <= n_next;
							i_q <= '0;
							j_q <= AW'(1);
							k_q <= '0;
							state_q <= (n_next < CNT_W'(2)) ? S_E_RD : S_P_RDI;
						end
					end
				end
				S_P_RDI: state_q <= S_P_RDJ;
				S_P_RDJ: state_q <= S_P_DIF;
				S_P_DIF: begin
					ax_q    <= '0;
					state_q <= S_SQ_GO;
				end
				S_SQ_GO: state_q <= S_SQ_W;
				S_SQ_W: begin
					if (mul_done) begin
						if (ax_q == 2'd2) begin
							ax_q    <= '0;
							state_q <= S_RT_GO;
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_SQ_GO;
						end
					end
				end
				S_RT_GO: state_q <= S_RT_ST;
				S_RT_ST: state_q <= S_RT_W;
				S_RT_W:  if (sq_done) state_q <= S_DN_GO;
				S_DN_GO: state_q <= S_DN_W;
				S_DN_W: begin
					if (mul_done) begin
						side_q  <= 1'b0;
						ax_q    <= '0;
						state_q <= S_GM_GO;
					end
				end
				S_GM_GO: state_q <= S_GM_W;
				S_GM_W:  if (mul_done) state_q <= S_NM_GO;
				S_NM_GO: state_q <= S_NM_W;
				S_NM_W:  if (mul_done) state_q <= S_DV_GO;
				S_DV_GO: state_q <= S_DV_W;
				S_DV_W: begin
					if (dv_done) begin
						if (ax_q == 2'd2) begin
							ax_q <= '0;
							if (side_q) begin
								side_q  <= 1'b0;
								state_q <= S_AI_RD;
							end else begin
								side_q  <= 1'b1;
								state_q <= S_GM_GO;
							end
						end else begin
							ax_q    <= ax_q + 2'd1;
							state_q <= S_GM_GO;
						end
					end
				end
				S_AI_RD: state_q <= S_AI_WR;
				S_AI_WR: state_q <= S_AJ_RD;
				S_AJ_RD: state_q <= S_AJ_WR;
				S_AJ_WR: begin
					// advance j, then i; after the last pair go to output
					if (CNT_W'(j_q) == n_q - CNT_W'(1)) begin
						if (CNT_W'(i_q) == n_q - CNT_W'(2)) begin
							k_q     <= '0;
							state_q <= S_E_RD;
						end else begin
							i_q     <= i_q + AW'(1);
							j_q     <= i_q + AW'(2);
							state_q <= S_P_RDI;
						end
					end else begin
						j_q     <= j_q + AW'(1);
						state_q <= S_P_RDI;
					end
				end
				S_E_RD: state_q <= S_E_CAP;
				S_E_CAP: begin
					out_vld_q <= 1'b1;
					state_q   <= S_E_WAIT;
				end
				S_E_WAIT: begin
					if (out_ch.ready) begin
						out_vld_q <= 1'b0;
						if (out_last_q) begin
							// frame done: drop count, flag and accumulators
							cnt_q     <= '0;
							drop_q    <= 1'b0;
							acc_vld_q <= '0;
							state_q   <= S_IDLE;
						end else begin
							k_q     <= k_q + AW'(1);
							state_q <= S_E_RD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		acc_vld_s1 <= acc_vld_q[acc_raddr];
		case (state_q)
			S_P_RDJ: bi_q <= pos_rdata;
			S_P_DIF: begin
				bj_q   <= pos_rdata;
				d_q[0] <= DIF_W'(pos_rdata.x) - DIF_W'(bi_q.x);
				d_q[1] <= DIF_W'(pos_rdata.y) - DIF_W'(bi_q.y);
				d_q[2] <= DIF_W'(pos_rdata.z) - DIF_W'(bi_q.z);
				r2_q   <= '0;
			end
			S_SQ_W:  if (mul_done) r2_q <= r2_q + R2_W'(mul_prod[MUL_W-1:16]);
			S_RT_GO: r2_q <= r2_q + R2_W'(soft_q);
			S_RT_W:  if (sq_done) s_q <= sq_root;
			S_DN_W:  if (mul_done) den_q <= mul_prod[DEN_W-1:0];
			S_GM_W:  if (mul_done) gm_q <= mul_prod[MUL_W-1:0];
			S_NM_W:  if (mul_done) num_q <= {mul_prod[NUM_W-9:0], 8'b0};
			S_DV_W: begin
				// zero r2 means bodies at (near) zero distance with no softening: add nothing
				if (dv_done) begin
					term_q[side_q][ax_q] <= (r2_q == '0) ? '0 :
						make_term(dv_quot, d_sel[DIF_W-1] ^ side_q);
				end
			end
			S_E_CAP: begin
				out_idx_q  <= IDX_W'(k_q);
				out_acc_q  <= acc_cur;
				out_ovf_q  <= drop_q;
				out_last_q <= (CNT_W'(k_q) == n_q - CNT_W'(1));
			end
			default: ;
		endcase
	end

	assign in_ch.ready        = (state_q == S_IDLE);
	assign out_ch.valid       = out_vld_q;
	assign out_ch.body_index  = out_idx_q;
	assign out_ch.acc_x       = out_acc_q.x;
	assign out_ch.acc_y       = out_acc_q.y;
	assign out_ch.acc_z       = out_acc_q.z;
	assign out_ch.overflowed  = out_ovf_q;
	assign out_ch.last_result = out_last_q;
endmodule
`default_nettype wire

### rtl/core/nbp_checker.sv
// Port-level checks of the n-body pair block and their attachment to the top level.
`default_nettype none
module nbp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      in_valid,
	input logic                      in_ready,
	input logic                      in_last,
	input logic                      out_valid,
	input logic                      out_ready,
	input logic [nbp_pkg::IDX_W-1:0] out_index,
	input logic                      out_last
);
	import nbp_pkg::*;

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid))
		else $error("input taken while results are pending");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && out_last |=> !out_valid)
		else $error("result shown after final transaction of frame");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_index))
		else $error("stalled result changed");

	a_frame_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && in_last |=> !in_ready)
		else $error("still loading after closing body");

	a_top_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (out_index == IDX_W'(MAX_BODIES - 1)) |-> out_last)
		else $error("highest index not marked final");
endmodule

bind nbody_pairwise_acceleration_top nbp_checker u_nbp_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.in_last(in_ch.last_body),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_index(out_ch.body_index),
	.out_last(out_ch.last_result)
);
`default_nettype wire

### tb/tb_nbody_pairwise_acceleration_top.sv
// Self-checking testbench of the all-pairs softened gravity block.
`timescale 1ns / 100ps

module tb_nbody_pairwise_acceleration_top;
	import nbp_pkg::*;

	// Register index past the end of the register list; a write there is ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd2;
	// A full 64-body frame keeps both channels quiet while all its pairs are
	// computed; the limit allows about five times that.
	localparam int unsigned QUIET_LIMIT = 8000000;
	localparam longint SAT_HI = 64'sd140737488355327;
	localparam longint SAT_LO = -64'sd140737488355328;
	localparam longint unsigned TERM_CAP = 64'd140737488355328;

	typedef struct {
		logic [IDX_W-1:0]        idx;
		logic signed [ACC_W-1:0] ax;
		logic signed [ACC_W-1:0] ay;
		logic signed [ACC_W-1:0] az;
		bit                      ovf;
		bit                      last;
	} accel_rec_t;

	// Predicts the per-body accelerations of each frame and checks the results.
	class accel_scoreboard;
		longint unsigned grav;
		longint unsigned soften;
		body_t           bodies[MAX_BODIES];
		int unsigned     count;
		bit              dropped;
		accel_rec_t      pending[$];
		int unsigned     errors;

		function new();
			grav = GRAV_RST;
			soften = SOFT_RST;
			count = 0;
			dropped = 0;
			errors = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
			if (index == CFG_GRAV)
				grav = data[GRAV_W-1:0];
			else if (index == CFG_SOFT)
				soften = data[SOFT_W-1:0];
		endfunction

		function longint unsigned sq_q16(longint d);
			longint unsigned m;
			m = d < 0 ? longint'(-d) : longint'(d);
			return (m * m) >> 16;
		endfunction

		function longint unsigned root_q16(longint unsigned r2);
			logic [127:0] x;
			logic [127:0] t;
			longint unsigned s;
			s = 0;
			x = {64'd0, r2} << 32;
			for (int b = 43; b >= 0; b--) begin
				t = {64'd0, s | (64'd1 << b)};
				if (t * t <= x)
					s = t[63:0];
			end
			return s;
		endfunction

		function longint pair_force(longint unsigned m, longint d, longint unsigned r2,
			longint unsigned s);
			logic [127:0] num;
			logic [127:0] den;
			logic [127:0] q;
			longint unsigned mag;
			longint unsigned qm;
			if (r2 == 0 || s == 0 || m == 0 || d == 0)
				return 0;
			mag = d < 0 ? longint'(-d) : longint'(d);
			num = ({64'd0, grav * m} * {64'd0, mag}) << 8;
			den = {64'd0, r2} * {64'd0, s};
			q = num / den;
			qm = (q > {64'd0, TERM_CAP}) ? TERM_CAP : q[63:0];
			return d < 0 ? -longint'(qm) : longint'(qm);
		endfunction

		function longint sat_add(longint a, longint t);
			longint s;
			s = a + t;
			if (s > SAT_HI) return SAT_HI;
			if (s < SAT_LO) return SAT_LO;
			return s;
		endfunction

		// Store the body; on the closing body, run every pair and queue one result per body.
		function void note_body(body_t b, bit last);
			longint acc[MAX_BODIES][3];
			longint d[3];
			longint unsigned r2;
			longint unsigned s;
			accel_rec_t rec;
			if (count < MAX_BODIES) begin
				bodies[count] = b;
				count++;
			end else begin
				dropped = 1;
			end
			if (!last)
				return;
			for (int i = 0; i < MAX_BODIES; i++)
				for (int k = 0; k < 3; k++)
					acc[i][k] = 0;
			for (int i = 0; i < count; i++) begin
				for (int j = i + 1; j < count; j++) begin
					d[0] = longint'(bodies[j].x) - longint'(bodies[i].x);
					d[1] = longint'(bodies[j].y) - longint'(bodies[i].y);
					d[2] = longint'(bodies[j].z) - longint'(bodies[i].z);
					r2 = sq_q16(d[0]) + sq_q16(d[1]) + sq_q16(d[2]) + soften;
					s = r2 != 0 ? root_q16(r2) : 0;
					for (int k = 0; k < 3; k++)
						acc[i][k] = sat_add(acc[i][k], pair_force(bodies[j].m, d[k], r2, s));
					for (int k = 0; k < 3; k++)
						acc[j][k] = sat_add(acc[j][k], -pair_force(bodies[i].m, d[k], r2, s));
				end
			end
			for (int i = 0; i < count; i++) begin
				rec.idx = i[IDX_W-1:0];
				rec.ax = acc[i][0][ACC_W-1:0];
				rec.ay = acc[i][1][ACC_W-1:0];
				rec.az = acc[i][2][ACC_W-1:0];
				rec.ovf = dropped;
				rec.last = (i + 1 == count);
				pending.push_back(rec);
			end
			count = 0;
			dropped = 0;
		endfunction

		function void mismatch(string field, longint exp_v, longint act_v);
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, field, exp_v, act_v);
			errors++;
		endfunction

		function void check_result(accel_rec_t got);
			accel_rec_t want;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result for body %0d", $time, got.idx);
				errors++;
				return;
			end
			want = pending.pop_front();
			if (got.idx !== want.idx) mismatch("body_index", want.idx, got.idx);
			if (got.ax !== want.ax) mismatch("acc_x", want.ax, got.ax);
			if (got.ay !== want.ay) mismatch("acc_y", want.ay, got.ay);
			if (got.az !== want.az) mismatch("acc_z", want.az, got.az);
			if (got.ovf !== want.ovf) mismatch("overflowed", want.ovf, got.ovf);
			if (got.last !== want.last) mismatch("last_result", want.last, got.last);
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	nbp_in_if  in_ch();
	nbp_out_if out_ch();

	nbody_pairwise_acceleration_top uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch.sink),
		.out_ch(out_ch.source),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	accel_scoreboard sb = new();
	int unsigned     burst_left = 0;
	int unsigned     quiet_cycles = 0;
	accel_rec_t      seen;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Check every result transaction against the oldest prediction.
	always @(posedge clk) begin
		if (out_ch.valid && out_ch.ready) begin
			seen.idx = out_ch.body_index;
			seen.ax = out_ch.acc_x;
			seen.ay = out_ch.acc_y;
			seen.az = out_ch.acc_z;
			seen.ovf = out_ch.overflowed;
			seen.last = out_ch.last_result;
			sb.check_result(seen);
		end
	end

	// Watchdog: count cycles in which neither channel moves a transaction.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
			$display("nbody_pairwise_acceleration_top test failed");
			$finish;
		end
	end

	// Receiver backpressure: switch at random between always ready, coin-flip
	// stalls and long stalls, so stalls can land on any result of a frame.
	initial begin : out_stall
		int unsigned mode;
		mode = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if ($urandom_range(0, 199) == 0)
				mode = $urandom_range(0, 2);
			case (mode)
				0: out_ch.ready = 1'b1;
				1: out_ch.ready = 1'($urandom_range(0, 1));
				default: out_ch.ready = ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	// Drive one body and hold it until taken; the sender works in bursts with gaps.
	task automatic send_body(input body_t b, input bit last);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			in_ch.valid = 1'b0;
			repeat ($urandom_range(0, 4)) @(negedge clk);
		end
		burst_left--;
		in_ch.pos_x = b.x;
		in_ch.pos_y = b.y;
		in_ch.pos_z = b.z;
		in_ch.body_mass = b.m;
		in_ch.last_body = last;
		in_ch.valid = 1'b1;
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		sb.note_body(b, last);
		@(negedge clk);
		in_ch.valid = 1'b0;
	endtask

	// Wait until every predicted result has arrived, then let the block settle.
	task automatic drain();
		while (sb.pending.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [CFG_DATA_W-1:0] data);
		cfg_we = 1'b1;
		cfg_index = index;
		cfg_data = data;
		@(negedge clk);
		cfg_we = 1'b0;
		sb.set_reg(index, data);
	endtask

	function automatic body_t mk_body(logic [31:0] x, logic [31:0] y, logic [31:0] z,
		logic [31:0] m);
		body_t b;
		b.x = x;
		b.y = y;
		b.z = z;
		b.m = m;
		return b;
	endfunction

	function automatic logic [31:0] rand_coord(int unsigned mode, logic [31:0] center);
		case (mode)
			0: return $urandom;
			1: return center + $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
			default: begin
				case ($urandom_range(0, 3))
					0: return 32'h7fff_ffff;
					1: return 32'h8000_0000;
					2: return 32'h0;
					default: return $urandom;
				endcase
			end
		endcase
	endfunction

	function automatic logic [31:0] rand_mass();
		case ($urandom_range(0, 9))
			0: return 32'h0;
			1: return 32'hffff_ffff;
			2, 3, 4: return $urandom;
			default: return $urandom_range(0, 32'h0100_0000);
		endcase
	endfunction

	// Send one frame of random bodies; most frames cluster, some spread or sit on extremes.
	task automatic send_frame(input int unsigned n);
		int unsigned mode;
		logic [31:0] center;
		mode = ($urandom_range(0, 9) < 6) ? 1 : $urandom_range(0, 2);
		center = $urandom;
		for (int unsigned k = 0; k < n; k++)
			send_body(mk_body(rand_coord(mode, center), rand_coord(mode, center),
				rand_coord(mode, center), rand_mass()), k + 1 == n);
	endtask

	task automatic rand_config();
		if ($urandom_range(0, 1))
			write_reg(CFG_GRAV, $urandom_range(0, 1) ? 40'($urandom) :
				40'($urandom_range(0, 32'h0400_0000)));
		if ($urandom_range(0, 1))
			write_reg(CFG_SOFT, {8'($urandom_range(0, 255)), $urandom} | 40'd1);
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.pos_x = '0;
		in_ch.pos_y = '0;
		in_ch.pos_z = '0;
		in_ch.body_mass = '0;
		in_ch.last_body = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Single body: no pairs, zero acceleration.
		send_body(mk_body(32'h7fff_ffff, 32'h8000_0000, 32'h0, 32'hffff_ffff), 1'b1);
		// Opposite corners with full mass.
		send_body(mk_body(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff), 1'b1);
		// Coincident pair, a zero-mass body along x and a near neighbor off that axis.
		send_body(mk_body(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000), 1'b0);
		send_body(mk_body(32'h0001_0000, 32'h0, 32'h0, 32'h0001_0000), 1'b0);
		send_body(mk_body(32'h0002_0000, 32'h0, 32'h0, 32'h0), 1'b0);
		send_body(mk_body(32'h0001_0000, 32'h0000_8000, 32'hffff_0000, 32'h0100_0000), 1'b1);
		drain();

		// Extreme registers: strongest G, widest softening.
		write_reg(CFG_GRAV, 40'hff_ffff_ffff);
		write_reg(CFG_SOFT, 40'hff_ffff_ffff);
		send_body(mk_body(32'h0, 32'h0, 32'h0, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h0000_0100, 32'h0, 32'h0, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h7fff_ffff, 32'h8000_0000, 32'h1234_5678, 32'h0000_0001), 1'b1);
		drain();

		// Zero G silences every pair; a write to an unused index changes nothing.
		write_reg(CFG_GRAV, 40'd0);
		write_reg(CFG_SPARE, 40'hff_ffff_ffff);
		send_body(mk_body(32'h0, 32'h0, 32'h0, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hffff_ffff), 1'b1);
		drain();

		// Smallest softening with close, heavy bodies drives the sums into saturation.
		write_reg(CFG_GRAV, 40'h00_ffff_ffff);
		write_reg(CFG_SOFT, 40'd1);
		send_body(mk_body(32'h0, 32'h0, 32'h0, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h0000_0001, 32'h0, 32'h0, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h0, 32'hffff_ffff, 32'h0, 32'hffff_ffff), 1'b0);
		send_body(mk_body(32'h0, 32'h0, 32'h0, 32'hffff_ffff), 1'b1);
		drain();

		// Overflow: fill the store, drop two bodies, close the frame on a dropped one.
		write_reg(CFG_GRAV, 40'd16777216);
		write_reg(CFG_SOFT, 40'd65536);
		send_frame(MAX_BODIES + 2);
		drain();

		// Random frames, mostly small, with the registers changed between some of them.
		for (int f = 0; f < 90; f++) begin
			if ($urandom_range(0, 4) == 0) begin
				drain();
				rand_config();
			end
			send_frame(($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5));
		end
		drain();
		repeat (100) @(negedge clk);

		if (sb.errors == 0)
			$display("nbody_pairwise_acceleration_top test passed");
		else
			$display("nbody_pairwise_acceleration_top test failed");
		$finish;
	end
endmodule
